// ----- src/tefrl_pkg.sv -----
`timescale 1ns / 1ps
package tefrl_pkg;

    // Default sizes
    localparam int RANGE_SLOTS_DEF = 8;
    localparam int WATCH_DEPTH_DEF = 32;
    localparam int LOG_DEPTH_DEF   = 8192;

    // Operation codes
    localparam logic [3:0] OP_ENTRY   = 4'd0;
    localparam logic [3:0] OP_EXIT    = 4'd1;
    localparam logic [3:0] OP_READ    = 4'd2;
    localparam logic [3:0] OP_DEFINE  = 4'd3;
    localparam logic [3:0] OP_ENABLE  = 4'd4;
    localparam logic [3:0] OP_DISABLE = 4'd5;
    localparam logic [3:0] OP_REMOVE  = 4'd6;
    localparam logic [3:0] OP_ADD_PID = 4'd7;
    localparam logic [3:0] OP_CLR_PID = 4'd8;

    // Status codes
    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_FILTERED = 4'd1;
    localparam logic [3:0] ST_BADPC    = 4'd2;
    localparam logic [3:0] ST_EMPTY    = 4'd3;
    localparam logic [3:0] ST_BADRANGE = 4'd4;
    localparam logic [3:0] ST_USED     = 4'd5;
    localparam logic [3:0] ST_OVERLAP  = 4'd6;
    localparam logic [3:0] ST_NOSLOT   = 4'd7;
    localparam logic [3:0] ST_FULL     = 4'd8;

    // Configuration register indexes
    localparam logic [1:0] CFG_ALL_MODE  = 2'd0;
    localparam logic [1:0] CFG_SIZE_EXP  = 2'd1;
    localparam logic [1:0] CFG_CODE_SIZE = 2'd2;

    localparam logic [3:0]  SIZE_EXP_RST  = 4'd13;
    localparam logic [31:0] CODE_SIZE_RST = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [31:0] pc_offset;
        logic [31:0] range_last;
        logic [2:0]  slot;
        logic [63:0] stamp;
        logic [7:0]  cpu;
        logic        has_process;
        logic [31:0] proc_id;
        logic [63:0] arg_one;
        logic [63:0] arg_two;
        logic [63:0] arg_three;
        logic [63:0] arg_four;
    } evt_t;

    typedef struct packed {
        logic        is_exit;
        logic [31:0] pc;
        logic [63:0] stamp;
        logic [31:0] proc_id;
        logic [7:0]  cpu;
        logic [63:0] arg_one;
        logic [63:0] arg_two;
        logic [63:0] arg_three;
        logic [63:0] arg_four;
    } rec_t;

    typedef struct packed {
        logic [3:0]  status;
        rec_t        rec;
        logic [13:0] pending;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic occ_ok;
    } dp_stat_t;

    typedef struct packed {
        logic        we;
        logic [1:0]  idx;
        logic [31:0] wdata;
    } cfg_wr_t;

endpackage

// ----- src/tefrl_in_if.sv -----
`timescale 1ns / 1ps
interface tefrl_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  opcode;
    logic [31:0] pc_offset;
    logic [31:0] range_last;
    logic [2:0]  slot;
    logic [63:0] stamp;
    logic [7:0]  cpu;
    logic        has_process;
    logic [31:0] proc_id;
    logic [63:0] arg_one;
    logic [63:0] arg_two;
    logic [63:0] arg_three;
    logic [63:0] arg_four;

    modport source (
        output valid, opcode, pc_offset, range_last, slot, stamp, cpu, has_process,
               proc_id, arg_one, arg_two, arg_three, arg_four,
        input  ready
    );
    modport sink (
        input  valid, opcode, pc_offset, range_last, slot, stamp, cpu, has_process,
               proc_id, arg_one, arg_two, arg_three, arg_four,
        output ready
    );
endinterface

// ----- src/tefrl_out_if.sv -----
`timescale 1ns / 1ps
interface tefrl_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic        rec_is_exit;
    logic [31:0] rec_pc;
    logic [63:0] rec_stamp;
    logic [31:0] rec_proc;
    logic [7:0]  rec_cpu;
    logic [63:0] rec_arg_one;
    logic [63:0] rec_arg_two;
    logic [63:0] rec_arg_three;
    logic [63:0] rec_arg_four;
    logic [13:0] pending;

    modport source (
        output valid, status, rec_is_exit, rec_pc, rec_stamp, rec_proc, rec_cpu,
               rec_arg_one, rec_arg_two, rec_arg_three, rec_arg_four, pending,
        input  ready
    );
    modport sink (
        input  valid, status, rec_is_exit, rec_pc, rec_stamp, rec_proc, rec_cpu,
               rec_arg_one, rec_arg_two, rec_arg_three, rec_arg_four, pending,
        output ready
    );
endinterface

// ----- src/trace_event_filter_ring_logger.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Role
// evt      in   trace event or command word (valid/ready)
// rsp      out  status, read record and pending count (valid/ready)
// apb      in   configuration registers at 0x0, 0x4, 0x8
//
// Each word passes through three steps: capture, execute (range/pid compares, one
// log memory access), load of the result register; a busy rsp holds back the load.
// A new word is taken while the previous result still waits on rsp.
// Reset clears the range valid bits, pid count and ring indices; log and
// watch list contents are undefined until written.
module trace_event_filter_ring_logger #(
    parameter int RANGE_SLOTS = tefrl_pkg::RANGE_SLOTS_DEF,
    parameter int WATCH_DEPTH = tefrl_pkg::WATCH_DEPTH_DEF,
    parameter int LOG_DEPTH   = tefrl_pkg::LOG_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    tefrl_in_if.sink    evt,
    tefrl_out_if.source rsp
);
    import tefrl_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t dp_st;
    cfg_wr_t  cfg_wr;
    evt_t     evt_d;
    rsp_t     rsp_d;

    // Decode the configuration port
    assign pready       = 1'b1;
    assign cfg_wr.we    = psel && penable && pwrite;
    assign cfg_wr.idx   = paddr[3:2];
    assign cfg_wr.wdata = pwdata;

    // Pack the incoming word
    always_comb
    begin
        evt_d.opcode      = evt.opcode;
        evt_d.pc_offset   = evt.pc_offset;
        evt_d.range_last  = evt.range_last;
        evt_d.slot        = evt.slot;
        evt_d.stamp       = evt.stamp;
        evt_d.cpu         = evt.cpu;
        evt_d.has_process = evt.has_process;
        evt_d.proc_id     = evt.proc_id;
        evt_d.arg_one     = evt.arg_one;
        evt_d.arg_two     = evt.arg_two;
        evt_d.arg_three   = evt.arg_three;
        evt_d.arg_four    = evt.arg_four;
    end

    tefrl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (evt.valid),
        .in_ready  (evt.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    tefrl_dp #(
        .RANGE_SLOTS (RANGE_SLOTS),
        .WATCH_DEPTH (WATCH_DEPTH),
        .LOG_DEPTH   (LOG_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (dp_st),
        .cfg_wr    (cfg_wr),
        .cfg_ridx  (paddr[3:2]),
        .cfg_rdata (prdata),
        .evt_in    (evt_d),
        .rsp_out   (rsp_d)
    );

    // Unpack the result word
    assign rsp.status        = rsp_d.status;
    assign rsp.rec_is_exit   = rsp_d.rec.is_exit;
    assign rsp.rec_pc        = rsp_d.rec.pc;
    assign rsp.rec_stamp     = rsp_d.rec.stamp;
    assign rsp.rec_proc      = rsp_d.rec.proc_id;
    assign rsp.rec_cpu       = rsp_d.rec.cpu;
    assign rsp.rec_arg_one   = rsp_d.rec.arg_one;
    assign rsp.rec_arg_two   = rsp_d.rec.arg_two;
    assign rsp.rec_arg_three = rsp_d.rec.arg_three;
    assign rsp.rec_arg_four  = rsp_d.rec.arg_four;
    assign rsp.pending       = rsp_d.pending;

`ifndef NO_ASSERTIONS
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (evt.valid && evt.ready) |=> cmd.exec)
        else $error("accepted word not executed");

    a_exec_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> !evt.ready)
        else $error("word taken before result loaded");

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        dp_st.occ_ok)
        else $error("ring occupancy above ring size");

    a_empty_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == ST_EMPTY)) |-> (rsp.pending == 14'd0))
        else $error("empty read with records pending");
`endif

endmodule

// ----- src/tefrl_ctrl.sv -----
`timescale 1ns / 1ps
module tefrl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output tefrl_pkg::dp_cmd_t cmd
);
    import tefrl_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // Sequence one word: capture, execute, load the result register
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- src/tefrl_dp.sv -----
`timescale 1ns / 1ps
module tefrl_dp #(
    parameter int RANGE_SLOTS = tefrl_pkg::RANGE_SLOTS_DEF,
    parameter int WATCH_DEPTH = tefrl_pkg::WATCH_DEPTH_DEF,
    parameter int LOG_DEPTH   = tefrl_pkg::LOG_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tefrl_pkg::dp_cmd_t  cmd,
    output tefrl_pkg::dp_stat_t st,
    input  tefrl_pkg::cfg_wr_t  cfg_wr,
    input  logic [1:0]          cfg_ridx,
    output logic [31:0]         cfg_rdata,
    input  tefrl_pkg::evt_t     evt_in,
    output tefrl_pkg::rsp_t     rsp_out
);
    import tefrl_pkg::*;

    localparam int CAP_EXP   = $clog2(LOG_DEPTH + 1) - 1;
    localparam int IW        = CAP_EXP + 1;
    localparam int AW        = CAP_EXP;
    localparam int MEM_DEPTH = 1 << CAP_EXP;
    localparam int SW        = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
    localparam int WCW       = $clog2(WATCH_DEPTH + 1);
    localparam int WIW       = (WATCH_DEPTH > 1) ? $clog2(WATCH_DEPTH) : 1;

    // Configuration
    logic        all_mode_reg;
    logic [3:0]  size_exp_reg;
    logic [31:0] code_size_reg;

    // Captured word
    evt_t        evt_reg;

    // Range table
    logic [31:0]            first_reg [RANGE_SLOTS];
    logic [31:0]            final_reg [RANGE_SLOTS];
    logic [RANGE_SLOTS-1:0] valid_reg, valid_next;
    logic [RANGE_SLOTS-1:0] on_reg, on_next;
    logic                   range_we;

    // Watch list
    logic [31:0]  watch_reg [WATCH_DEPTH];
    logic [WCW-1:0] wcount_reg, wcount_next;
    logic           watch_we;

    // Ring indices and log memory
    logic [IW-1:0] widx_reg, widx_next;
    logic [IW-1:0] ridx_reg, ridx_next;
    rec_t          mem [MEM_DEPTH];
    rec_t          rdata_reg;
    rec_t          wrec;
    logic          mem_we, mem_re;

    // Result
    logic [3:0] status_reg, status_next;
    logic       rec_sel_reg, rec_sel_next;
    rsp_t       rsp_reg;

    logic [4:0]    eff_exp;
    logic [IW-1:0] size, mask, count;
    logic [AW-1:0] waddr, raddr;
    logic [SW-1:0] sidx;
    logic          slot_ok, pc_bad, covered, overlap, watch_hit, watched, is_exit;

    // Ring geometry
    always_comb
    begin
        eff_exp = ({1'b0, size_exp_reg} < 5'(CAP_EXP)) ? {1'b0, size_exp_reg} : 5'(CAP_EXP);
        size    = IW'(1) << eff_exp;
        mask    = size - IW'(1);
        count   = widx_reg - ridx_reg;
        waddr   = AW'(widx_reg & mask);
        raddr   = AW'(ridx_reg & mask);
    end

    // Range and pid compares over all slots at once
    always_comb
    begin
        sidx    = SW'(evt_reg.slot);
        slot_ok = (32'(evt_reg.slot) < 32'(RANGE_SLOTS));
        pc_bad  = (evt_reg.pc_offset > code_size_reg);
        covered = 1'b0;
        overlap = 1'b0;
        for (int i = 0; i < RANGE_SLOTS; i++)
        begin
            if (valid_reg[i] && on_reg[i] && (first_reg[i] <= evt_reg.pc_offset)
                && (evt_reg.pc_offset <= final_reg[i]))
            begin
                covered = 1'b1;
            end
            if (valid_reg[i] && (first_reg[i] <= evt_reg.range_last)
                && (evt_reg.pc_offset <= final_reg[i]))
            begin
                overlap = 1'b1;
            end
        end
        watch_hit = 1'b0;
        for (int j = 0; j < WATCH_DEPTH; j++)
        begin
            if ((WCW'(j) < wcount_reg) && (watch_reg[j] == evt_reg.proc_id))
            begin
                watch_hit = 1'b1;
            end
        end
        watched = (wcount_reg == '0) || watch_hit;
    end

    // Build the log record
    always_comb
    begin
        is_exit        = (evt_reg.opcode == OP_EXIT);
        wrec.is_exit   = is_exit;
        wrec.pc        = evt_reg.pc_offset;
        wrec.stamp     = evt_reg.stamp;
        wrec.proc_id   = evt_reg.has_process ? evt_reg.proc_id : 32'hFFFF_FFFF;
        wrec.cpu       = evt_reg.cpu;
        wrec.arg_one   = evt_reg.arg_one;
        wrec.arg_two   = is_exit ? 64'd0 : evt_reg.arg_two;
        wrec.arg_three = is_exit ? 64'd0 : evt_reg.arg_three;
        wrec.arg_four  = is_exit ? 64'd0 : evt_reg.arg_four;
    end

    // Decide the operation
    always_comb
    begin
        status_next  = ST_OK;
        rec_sel_next = 1'b0;
        widx_next    = widx_reg;
        ridx_next    = ridx_reg;
        valid_next   = valid_reg;
        on_next      = on_reg;
        wcount_next  = wcount_reg;
        range_we     = 1'b0;
        watch_we     = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        unique case (evt_reg.opcode)
            OP_ENTRY, OP_EXIT:
            begin
                if (pc_bad)
                begin
                    status_next = ST_BADPC;
                end
                else if (!covered)
                begin
                    status_next = ST_FILTERED;
                end
                else if (!all_mode_reg && (!evt_reg.has_process || !watched))
                begin
                    status_next = ST_FILTERED;
                end
                else
                begin
                    mem_we    = 1'b1;
                    widx_next = widx_reg + IW'(1);
                    // drop the oldest word when the ring is full
                    if (count == size)
                    begin
                        ridx_next = ridx_reg + IW'(1);
                    end
                end
            end
            OP_READ:
            begin
                if (count == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    mem_re       = 1'b1;
                    rec_sel_next = 1'b1;
                    ridx_next    = ridx_reg + IW'(1);
                end
            end
            OP_DEFINE:
            begin
                if (!slot_ok)
                begin
                    status_next = ST_NOSLOT;
                end
                else if ((evt_reg.pc_offset > evt_reg.range_last)
                         || (evt_reg.range_last > code_size_reg))
                begin
                    status_next = ST_BADRANGE;
                end
                else if (valid_reg[sidx])
                begin
                    status_next = ST_USED;
                end
                else if (overlap)
                begin
                    status_next = ST_OVERLAP;
                end
                else
                begin
                    range_we         = 1'b1;
                    valid_next[sidx] = 1'b1;
                    on_next[sidx]    = 1'b0;
                end
            end
            OP_ENABLE, OP_DISABLE, OP_REMOVE:
            begin
                if (!slot_ok || !valid_reg[sidx])
                begin
                    status_next = ST_NOSLOT;
                end
                else if (evt_reg.opcode == OP_ENABLE)
                begin
                    on_next[sidx] = 1'b1;
                end
                else if (evt_reg.opcode == OP_DISABLE)
                begin
                    on_next[sidx] = 1'b0;
                end
                else
                begin
                    valid_next[sidx] = 1'b0;
                    on_next[sidx]    = 1'b0;
                end
            end
            OP_ADD_PID:
            begin
                if (evt_reg.proc_id == 32'd0)
                begin
                    wcount_next = '0;
                end
                else if (wcount_reg == WCW'(WATCH_DEPTH))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    watch_we    = 1'b1;
                    wcount_next = wcount_reg + WCW'(1);
                end
            end
            OP_CLR_PID:
            begin
                wcount_next = '0;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_mode_reg  <= 1'b0;
            size_exp_reg  <= SIZE_EXP_RST;
            code_size_reg <= CODE_SIZE_RST;
        end
        else if (cfg_wr.we)
        begin
            unique case (cfg_wr.idx)
                CFG_ALL_MODE:  all_mode_reg  <= cfg_wr.wdata[0];
                CFG_SIZE_EXP:  size_exp_reg  <= cfg_wr.wdata[3:0];
                CFG_CODE_SIZE: code_size_reg <= cfg_wr.wdata;
                default:       all_mode_reg  <= all_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_ridx)
            CFG_ALL_MODE:  cfg_rdata = {31'd0, all_mode_reg};
            CFG_SIZE_EXP:  cfg_rdata = {28'd0, size_exp_reg};
            CFG_CODE_SIZE: cfg_rdata = code_size_reg;
            default:       cfg_rdata = 32'd0;
        endcase
    end

    // Control state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            on_reg     <= '0;
            wcount_reg <= '0;
            widx_reg   <= '0;
            ridx_reg   <= '0;
        end
        else if (cmd.exec)
        begin
            valid_reg  <= valid_next;
            on_reg     <= on_next;
            wcount_reg <= wcount_next;
            widx_reg   <= widx_next;
            ridx_reg   <= ridx_next;
        end
        else if (cfg_wr.we && (cfg_wr.idx == CFG_SIZE_EXP))
        begin
            // resizing empties the ring unless a word is executing
            widx_reg <= '0;
            ridx_reg <= '0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            evt_reg <= evt_in;
        end
        if (cmd.exec)
        begin
            status_reg  <= status_next;
            rec_sel_reg <= rec_sel_next;
            if (range_we)
            begin
                first_reg[sidx] <= evt_reg.pc_offset;
                final_reg[sidx] <= evt_reg.range_last;
            end
            if (watch_we)
            begin
                watch_reg[WIW'(wcount_reg)] <= evt_reg.proc_id;
            end
        end
        if (cmd.load_out)
        begin
            rsp_reg.status  <= status_reg;
            rsp_reg.rec     <= rec_sel_reg ? rdata_reg : '0;
            rsp_reg.pending <= 14'(count);
        end
    end

    // Log memory
    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_we)
        begin
            mem[waddr] <= wrec;
        end
        if (cmd.exec && mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign st.occ_ok = (count <= size);
    assign rsp_out   = rsp_reg;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import tefrl_pkg::*;

    localparam int SLOTS      = 8;
    localparam int WATCH_MAX  = 32;
    localparam int RING_MAX   = 8192;
    localparam int CYCLE_CAP  = 300000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tefrl_in_if  evt_ch ();
    tefrl_out_if rsp_ch ();

    trace_event_filter_ring_logger dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .evt     (evt_ch.sink),
        .rsp     (rsp_ch.source)
    );

    // Shadow of the block state
    logic [31:0] rng_lo [SLOTS];
    logic [31:0] rng_hi [SLOTS];
    logic        rng_valid [SLOTS];
    logic        rng_on [SLOTS];
    logic [31:0] watch_pids [WATCH_MAX];
    int unsigned watch_cnt;
    logic [31:0] wr_idx;
    logic [31:0] rd_idx;
    rec_t        ring_mem [RING_MAX];
    logic        mode_all;
    logic [3:0]  size_exp;
    logic [31:0] code_lim;

    evt_t        word_q [$];
    rsp_t        rsp_expect_q [$];
    int          fail_cnt;
    bit          idle_on;
    int          in_gap;
    int          out_gap;
    int unsigned cycle_cnt;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int unsigned ring_len();
        int unsigned want;
        want = 1 << size_exp;
        return (want < RING_MAX) ? want : RING_MAX;
    endfunction

    function automatic bit pc_covered(logic [31:0] pc);
        for (int i = 0; i < SLOTS; i++)
            if (rng_valid[i] && rng_on[i] && rng_lo[i] <= pc && pc <= rng_hi[i])
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit pid_watched(logic [31:0] pid);
        if (watch_cnt == 0)
            return 1'b1;
        for (int i = 0; i < watch_cnt; i++)
            if (watch_pids[i] == pid)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [3:0] log_word(evt_t e, bit is_exit);
        int unsigned sz;
        int unsigned at;
        rec_t        r;
        if (e.pc_offset > code_lim)
            return ST_BADPC;
        if (!pc_covered(e.pc_offset))
            return ST_FILTERED;
        if (!mode_all && (!e.has_process || !pid_watched(e.proc_id)))
            return ST_FILTERED;
        sz = ring_len();
        at = wr_idx & (sz - 1);
        r.is_exit   = is_exit;
        r.pc        = e.pc_offset;
        r.stamp     = e.stamp;
        r.proc_id   = e.has_process ? e.proc_id : 32'hFFFF_FFFF;
        r.cpu       = e.cpu;
        r.arg_one   = e.arg_one;
        r.arg_two   = is_exit ? 64'd0 : e.arg_two;
        r.arg_three = is_exit ? 64'd0 : e.arg_three;
        r.arg_four  = is_exit ? 64'd0 : e.arg_four;
        ring_mem[at] = r;
        wr_idx = wr_idx + 1;
        if (wr_idx - rd_idx > sz)
            rd_idx = wr_idx - sz;
        return ST_OK;
    endfunction

    function automatic logic [3:0] define_slot(evt_t e);
        if (e.pc_offset > e.range_last || e.range_last > code_lim)
            return ST_BADRANGE;
        if (rng_valid[e.slot])
            return ST_USED;
        for (int i = 0; i < SLOTS; i++)
            if (rng_valid[i] && rng_lo[i] <= e.range_last && e.pc_offset <= rng_hi[i])
                return ST_OVERLAP;
        rng_lo[e.slot]    = e.pc_offset;
        rng_hi[e.slot]    = e.range_last;
        rng_valid[e.slot] = 1'b1;
        rng_on[e.slot]    = 1'b0;
        return ST_OK;
    endfunction

    // Compute the response of one accepted word and advance the shadow state
    function automatic rsp_t trace_response(evt_t e);
        rsp_t        r;
        int unsigned sz;
        logic [31:0] cnt;
        r = '0;
        r.status = ST_OK;
        case (e.opcode)
            OP_ENTRY:   r.status = log_word(e, 1'b0);
            OP_EXIT:    r.status = log_word(e, 1'b1);
            OP_READ:
            begin
                sz = ring_len();
                if (wr_idx == rd_idx)
                    r.status = ST_EMPTY;
                else
                begin
                    if (wr_idx - rd_idx > sz)
                        rd_idx = wr_idx - sz;
                    r.rec  = ring_mem[rd_idx & (sz - 1)];
                    rd_idx = rd_idx + 1;
                end
            end
            OP_DEFINE:  r.status = define_slot(e);
            OP_ENABLE, OP_DISABLE, OP_REMOVE:
            begin
                if (!rng_valid[e.slot])
                    r.status = ST_NOSLOT;
                else if (e.opcode == OP_ENABLE)
                    rng_on[e.slot] = 1'b1;
                else if (e.opcode == OP_DISABLE)
                    rng_on[e.slot] = 1'b0;
                else
                begin
                    rng_valid[e.slot] = 1'b0;
                    rng_on[e.slot]    = 1'b0;
                end
            end
            OP_ADD_PID:
            begin
                if (e.proc_id == 32'd0)
                    watch_cnt = 0;
                else if (watch_cnt >= WATCH_MAX)
                    r.status = ST_FULL;
                else
                begin
                    watch_pids[watch_cnt] = e.proc_id;
                    watch_cnt++;
                end
            end
            OP_CLR_PID: watch_cnt = 0;
            default: ;
        endcase
        sz  = ring_len();
        cnt = wr_idx - rd_idx;
        if (cnt > sz)
            cnt = sz;
        r.pending = cnt[13:0];
        return r;
    endfunction

    task automatic check_field(string nm, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t mismatch %s expected %h actual %h", $realtime, nm, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    // Check responses, predict accepted words, drive the next word and ready
    always @(posedge clk)
    begin
        rsp_t exp_r;
        evt_t acc;
        evt_t nxt;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (rsp_expect_q.size() == 0)
                begin
                    $display("%0t unexpected response status %h", $realtime, rsp_ch.status);
                    fail_cnt++;
                end
                else
                begin
                    exp_r = rsp_expect_q.pop_front();
                    check_field("status", exp_r.status, rsp_ch.status);
                    check_field("rec_is_exit", exp_r.rec.is_exit, rsp_ch.rec_is_exit);
                    check_field("rec_pc", exp_r.rec.pc, rsp_ch.rec_pc);
                    check_field("rec_stamp", exp_r.rec.stamp, rsp_ch.rec_stamp);
                    check_field("rec_proc", exp_r.rec.proc_id, rsp_ch.rec_proc);
                    check_field("rec_cpu", exp_r.rec.cpu, rsp_ch.rec_cpu);
                    check_field("rec_arg_one", exp_r.rec.arg_one, rsp_ch.rec_arg_one);
                    check_field("rec_arg_two", exp_r.rec.arg_two, rsp_ch.rec_arg_two);
                    check_field("rec_arg_three", exp_r.rec.arg_three, rsp_ch.rec_arg_three);
                    check_field("rec_arg_four", exp_r.rec.arg_four, rsp_ch.rec_arg_four);
                    check_field("pending", exp_r.pending, rsp_ch.pending);
                end
            end

            if (evt_ch.valid && evt_ch.ready)
            begin
                acc.opcode      = evt_ch.opcode;
                acc.pc_offset   = evt_ch.pc_offset;
                acc.range_last  = evt_ch.range_last;
                acc.slot        = evt_ch.slot;
                acc.stamp       = evt_ch.stamp;
                acc.cpu         = evt_ch.cpu;
                acc.has_process = evt_ch.has_process;
                acc.proc_id     = evt_ch.proc_id;
                acc.arg_one     = evt_ch.arg_one;
                acc.arg_two     = evt_ch.arg_two;
                acc.arg_three   = evt_ch.arg_three;
                acc.arg_four    = evt_ch.arg_four;
                rsp_expect_q.push_back(trace_response(acc));
            end

            // Advance the input side
            if (!evt_ch.valid || evt_ch.ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    evt_ch.valid <= 1'b0;
                end
                else if (word_q.size() > 0)
                begin
                    nxt = word_q.pop_front();
                    evt_ch.valid       <= 1'b1;
                    evt_ch.opcode      <= nxt.opcode;
                    evt_ch.pc_offset   <= nxt.pc_offset;
                    evt_ch.range_last  <= nxt.range_last;
                    evt_ch.slot        <= nxt.slot;
                    evt_ch.stamp       <= nxt.stamp;
                    evt_ch.cpu         <= nxt.cpu;
                    evt_ch.has_process <= nxt.has_process;
                    evt_ch.proc_id     <= nxt.proc_id;
                    evt_ch.arg_one     <= nxt.arg_one;
                    evt_ch.arg_two     <= nxt.arg_two;
                    evt_ch.arg_three   <= nxt.arg_three;
                    evt_ch.arg_four    <= nxt.arg_four;
                    if (idle_on && $urandom_range(0, 3) == 0)
                        in_gap = $urandom_range(1, 13);
                end
                else
                    evt_ch.valid <= 1'b0;
            end

            // Stall the output side in bursts
            if (out_gap > 0)
            begin
                out_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_gap = $urandom_range(1, 13);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_CAP)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic evt_t blank_word(logic [3:0] op);
        evt_t e;
        e = '0;
        e.opcode      = op;
        e.has_process = 1'b1;
        e.stamp       = rand64();
        e.cpu         = 8'($urandom_range(0, 255));
        e.arg_one     = rand64();
        e.arg_two     = rand64();
        e.arg_three   = rand64();
        e.arg_four    = rand64();
        return e;
    endfunction

    task automatic push_op(logic [3:0] op, logic [31:0] pc, logic [31:0] last,
                           logic [2:0] sl, logic hp, logic [31:0] pid);
        evt_t e;
        e = blank_word(op);
        e.pc_offset   = pc;
        e.range_last  = last;
        e.slot        = sl;
        e.has_process = hp;
        e.proc_id     = pid;
        word_q.push_back(e);
    endtask

    // Pick a pc near a slot region so about half land inside a range
    function automatic logic [31:0] pick_pc(logic [2:0] sl);
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return {1'b0, sl, 28'd0} + $urandom_range(0, 32'h1FFF);
    endfunction

    task automatic push_random(int n);
        evt_t        e;
        int unsigned pick;
        logic [2:0]  sl;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            sl   = 3'($urandom_range(0, 7));
            e = blank_word(OP_ENTRY);
            e.slot        = sl;
            e.range_last  = $urandom();
            e.has_process = ($urandom_range(0, 9) != 0);
            e.proc_id     = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(1, 6);
            e.pc_offset   = pick_pc(sl);
            if (pick < 45)
                e.opcode = OP_ENTRY;
            else if (pick < 60)
                e.opcode = OP_EXIT;
            else if (pick < 80)
                e.opcode = OP_READ;
            else if (pick < 86)
            begin
                e.opcode = OP_DEFINE;
                if ($urandom_range(0, 4) != 0)
                begin
                    e.pc_offset  = {1'b0, sl, 28'd0} + $urandom_range(0, 32'h800);
                    e.range_last = e.pc_offset + $urandom_range(0, 32'h1000);
                end
            end
            else if (pick < 91)
                e.opcode = OP_ENABLE;
            else if (pick < 94)
                e.opcode = OP_DISABLE;
            else if (pick < 95)
                e.opcode = OP_REMOVE;
            else if (pick < 98)
                e.opcode = OP_ADD_PID;
            else if (pick < 99)
                e.opcode = OP_CLR_PID;
            else
                e.opcode = 4'($urandom_range(9, 15));
            word_q.push_back(e);
        end
    endtask

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (word_q.size() != 0 || evt_ch.valid || rsp_expect_q.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            CFG_ALL_MODE: mode_all = val[0];
            CFG_SIZE_EXP:
            begin
                size_exp = val[3:0];
                wr_idx   = '0;
                rd_idx   = '0;
            end
            CFG_CODE_SIZE: code_lim = val;
            default: ;
        endcase
    endtask

    task automatic set_config(logic amode, logic [3:0] sexp, logic [31:0] climit);
        reg_write(CFG_ALL_MODE, {31'd0, amode});
        reg_write(CFG_SIZE_EXP, {28'd0, sexp});
        reg_write(CFG_CODE_SIZE, climit);
    endtask

    initial
    begin
        evt_t e;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        evt_ch.valid       = 1'b0;
        evt_ch.opcode      = '0;
        evt_ch.pc_offset   = '0;
        evt_ch.range_last  = '0;
        evt_ch.slot        = '0;
        evt_ch.stamp       = '0;
        evt_ch.cpu         = '0;
        evt_ch.has_process = 1'b0;
        evt_ch.proc_id     = '0;
        evt_ch.arg_one     = '0;
        evt_ch.arg_two     = '0;
        evt_ch.arg_three   = '0;
        evt_ch.arg_four    = '0;
        rsp_ch.ready       = 1'b0;
        fail_cnt  = 0;
        idle_on   = 1'b1;
        in_gap    = 0;
        out_gap   = 0;
        cycle_cnt = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            rng_lo[i]    = '0;
            rng_hi[i]    = '0;
            rng_valid[i] = 1'b0;
            rng_on[i]    = 1'b0;
        end
        watch_cnt = 0;
        wr_idx    = '0;
        rd_idx    = '0;
        mode_all  = 1'b0;
        size_exp  = SIZE_EXP_RST;
        code_lim  = CODE_SIZE_RST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: empty read, range table errors, filters, exit zeroing
        push_op(OP_READ, 0, 0, 0, 1, 1);
        push_op(OP_ENTRY, 0, 0, 0, 1, 1);
        push_op(OP_DEFINE, 32'h0, 32'hFFF, 0, 1, 1);
        push_op(OP_DEFINE, 32'h0, 32'hFFF, 0, 1, 1);
        push_op(OP_DEFINE, 32'hFFF, 32'h2000, 1, 1, 1);
        push_op(OP_DEFINE, 32'h5000, 32'h4000, 2, 1, 1);
        push_op(OP_ENABLE, 0, 0, 3'd2, 1, 1);
        push_op(OP_ENABLE, 0, 0, 0, 1, 1);
        push_op(OP_ENABLE, 0, 0, 0, 1, 1);
        push_op(OP_ENTRY, 0, 0, 0, 0, 5);
        push_op(OP_ENTRY, 0, 0, 0, 1, 5);
        push_op(OP_EXIT, 32'hFFF, 0, 0, 1, 32'hFFFF_FFFF);
        push_op(OP_READ, 0, 0, 0, 1, 1);
        push_op(OP_READ, 0, 0, 0, 1, 1);
        push_op(OP_READ, 0, 0, 0, 1, 1);
        push_op(OP_ADD_PID, 0, 0, 0, 1, 7);
        push_op(OP_ENTRY, 32'h10, 0, 0, 1, 5);
        push_op(OP_ENTRY, 32'h10, 0, 0, 1, 7);
        push_op(OP_ADD_PID, 0, 0, 0, 1, 0);
        push_op(OP_CLR_PID, 0, 0, 0, 1, 0);
        push_op(OP_DISABLE, 0, 0, 0, 1, 0);
        push_op(OP_DISABLE, 0, 0, 0, 1, 0);
        push_op(OP_ENTRY, 32'h20, 0, 0, 1, 5);
        push_op(OP_REMOVE, 0, 0, 0, 1, 0);
        push_op(OP_DEFINE, 32'hFFFF_0000, 32'hFFFF_FFFF, 3'd7, 1, 1);
        push_op(OP_ENABLE, 0, 0, 3'd7, 1, 1);
        e = blank_word(OP_ENTRY);
        e.pc_offset = 32'hFFFF_FFFF;
        e.slot      = 3'd7;
        e.stamp     = '1;
        e.cpu       = 8'hFF;
        e.proc_id   = 32'hFFFF_FFFF;
        e.arg_one   = '1;
        e.arg_two   = '1;
        e.arg_three = '1;
        e.arg_four  = '1;
        word_q.push_back(e);
        push_op(OP_READ, 0, 0, 0, 1, 1);

        // Set up regions in every slot so random events find ranges
        for (int s = 0; s < SLOTS; s++)
        begin
            push_op(OP_DEFINE, {1'b0, s[2:0], 28'd0}, {1'b0, s[2:0], 28'h0000FFF},
                    s[2:0], 1, 1);
            push_op(OP_ENABLE, 0, 0, s[2:0], 1, 1);
        end
        wait_drained();

        // Fill the watch list past its depth, then clear it
        for (int i = 0; i <= WATCH_MAX; i++)
            push_op(OP_ADD_PID, 0, 0, 0, 1, (i < 4) ? i + 1 : $urandom() | 32'h100);
        push_random(30);
        push_op(OP_CLR_PID, 0, 0, 0, 1, 0);
        push_random(60);
        // Hold off until every response has come back
        wait_drained();
        push_random(60);
        wait_drained();

        set_config(1'b1, 4'd2, 32'h4FFF_FFFF);
        push_random(100);
        wait_drained();

        set_config(1'b0, 4'd0, 32'h0);
        push_random(50);
        wait_drained();

        // Last part runs without idling
        set_config(1'b1, 4'd13, 32'hFFFF_FFFF);
        idle_on = 1'b0;
        push_random(70);
        wait_drained();
        repeat (10) @(posedge clk);

        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
src/tefrl_pkg.sv
src/tefrl_in_if.sv
src/tefrl_out_if.sv
src/tefrl_ctrl.sv
src/tefrl_dp.sv
src/trace_event_filter_ring_logger.sv
verif/tb_top.sv
